// ===== src/ppl_pkg.sv =====
package ppl_pkg;

  localparam int unsigned MaxChainHeadersDefault = 8;
  localparam int unsigned MaxFrameBytesDefault   = 65535;

  localparam logic [7:0] FixedHdrLen = 8'd8;
  localparam logic [5:0] WordBytes   = 6'd4;

  typedef enum logic [3:0] {
    KindEth  = 4'd0,
    KindIp4  = 4'd1,
    KindIp6  = 4'd2,
    KindTcp  = 4'd3,
    KindTerm = 4'd4,
    KindFrag = 4'd5,
    KindPay  = 4'd6,
    KindStop = 4'd7
  } hdr_kind_e;

  typedef enum logic [2:0] {
    VerdictPayload   = 3'd0,
    VerdictNonIp     = 3'd1,
    VerdictUnsupp    = 3'd2,
    VerdictNestedIp  = 3'd3,
    VerdictTruncated = 3'd4,
    VerdictChainLong = 3'd5
  } verdict_e;

  localparam logic [7:0] ProtoIcmp   = 8'd1;
  localparam logic [7:0] ProtoIpip   = 8'd4;
  localparam logic [7:0] ProtoTcp    = 8'd6;
  localparam logic [7:0] ProtoUdp    = 8'd17;
  localparam logic [7:0] ProtoIp6    = 8'd41;
  localparam logic [7:0] ProtoFrag   = 8'd44;
  localparam logic [7:0] ProtoEsp    = 8'd50;
  localparam logic [7:0] ProtoIcmp6  = 8'd58;

  localparam logic [15:0] EtherIp4  = 16'h0800;
  localparam logic [15:0] EtherIp6  = 16'h86DD;
  localparam logic [15:0] EtherVlan = 16'h8100;

  // Item moved from the classifying front to the back end.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        pay;
    logic [2:0]  sticky;
    logic [15:0] offset;
  } ppl_cls_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic        is_payload;
    logic        last_out;
    logic [2:0]  verdict;
    logic [15:0] payload_offset;
  } ppl_res_t;

endpackage

// ===== src/ppl_in_if.sv =====
interface ppl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

// ===== src/ppl_out_if.sv =====
interface ppl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_out;
  logic        is_payload;
  logic        last_out;
  logic [2:0]  verdict;
  logic [15:0] payload_offset;
  modport source (output valid, output data_out, output is_payload, output last_out,
                  output verdict, output payload_offset, input ready);
  modport sink (input valid, input data_out, input is_payload, input last_out,
                input verdict, input payload_offset, output ready);
endinterface

// ===== src/ppl_front.sv =====
module ppl_front #(
  parameter int unsigned MaxChainHeaders = ppl_pkg::MaxChainHeadersDefault,
  parameter int unsigned MaxFrameBytes   = ppl_pkg::MaxFrameBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        data_i,
  input  logic              last_i,
  output logic              ready_o,
  output logic              cls_valid_o,
  output ppl_pkg::ppl_cls_t cls_o,
  input  logic              cls_ready_i
);
  import ppl_pkg::*;

  localparam logic [15:0] MaxPos   = 16'(MaxFrameBytes);
  localparam logic [3:0]  MaxChain = 4'(MaxChainHeaders);

  hdr_kind_e   kind_q, kind_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] proto_q, proto_d;
  logic        tun_q, tun_d;
  logic [3:0]  chain_q, chain_d;
  logic [15:0] cur_q, cur_d;
  logic [2:0]  sticky_q, sticky_d;
  logic        fire;

  assign ready_o     = cls_ready_i;
  assign cls_valid_o = valid_i;
  assign fire        = valid_i && cls_ready_i;

  always_comb begin
    logic [8:0]  idx_inc;
    logic [16:0] sum;
    logic        do_enter;
    hdr_kind_e   en_kind;
    logic [7:0]  en_len;
    kind_d   = kind_q;
    idx_d    = idx_q;
    len_d    = len_q;
    proto_d  = proto_q;
    tun_d    = tun_q;
    chain_d  = chain_q;
    cur_d    = cur_q;
    sticky_d = sticky_q;
    do_enter = 1'b0;
    en_kind  = KindTerm;
    en_len   = FixedHdrLen;
    idx_inc  = {1'b0, idx_q} + 9'd1;
    sum      = {1'b0, cur_q} + {9'd0, len_q};
    if (kind_q != KindPay && kind_q != KindStop) begin
      unique case (kind_q)
        KindEth: begin
          if (idx_q == 8'd12 || idx_q == 8'd13 || idx_q == 8'd16 || idx_q == 8'd17) begin
            proto_d = {proto_q[7:0], data_i};
          end
          if (idx_q == 8'd13 && len_q == 8'd14 && {proto_q[7:0], data_i} == EtherVlan) begin
            len_d = 8'd18;
          end
        end
        KindIp4:  if (idx_q == 8'd9) proto_d = {8'd0, data_i};
        KindIp6:  if (idx_q == 8'd6) proto_d = {8'd0, data_i};
        KindFrag: if (idx_q == 8'd0) proto_d = {8'd0, data_i};
        KindTcp:  if (idx_q == 8'd12) len_d = {2'd0, data_i[7:4] * WordBytes};
        default: ;
      endcase
      sum = {1'b0, cur_q} + {9'd0, len_d};
      if (idx_inc >= {1'b0, len_d}) begin
        cur_d = sum[16] ? 16'hFFFF : sum[15:0];
        if (kind_q == KindEth) begin
          if (proto_d == EtherIp4) begin
            do_enter = 1'b1; en_kind = KindIp4; en_len = 8'd20;
          end else if (proto_d == EtherIp6) begin
            do_enter = 1'b1; en_kind = KindIp6; en_len = 8'd40;
          end else begin
            sticky_d = VerdictNonIp; kind_d = KindStop;
          end
        end else if (kind_q == KindIp4 || kind_q == KindIp6 || kind_q == KindFrag) begin
          priority case (proto_d[7:0])
            ProtoTcp: begin do_enter = 1'b1; en_kind = KindTcp; en_len = 8'd20; end
            ProtoIcmp, ProtoUdp, ProtoEsp, ProtoIcmp6: do_enter = 1'b1;
            ProtoIp6:  begin do_enter = 1'b1; en_len = 8'd40; end
            ProtoFrag: begin do_enter = 1'b1; en_kind = KindFrag; end
            ProtoIpip: begin
              if (tun_q) begin
                sticky_d = VerdictNestedIp; kind_d = KindStop;
              end else begin
                tun_d = 1'b1; do_enter = 1'b1; en_kind = KindIp4; en_len = 8'd20;
              end
            end
            default: begin sticky_d = VerdictUnsupp; kind_d = KindStop; end
          endcase
        end else begin
          kind_d = KindPay;
        end
        if (do_enter) begin
          if (chain_q >= MaxChain) begin
            sticky_d = VerdictChainLong; kind_d = KindStop;
          end else begin
            chain_d = chain_q + 4'd1;
            kind_d  = en_kind;
            len_d   = en_len;
            idx_d   = 8'd0;
            proto_d = 16'd0;
          end
        end
      end else begin
        idx_d = idx_inc[7:0];
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (pos_q < MaxPos) pos_d = pos_q + 16'd1;
    cls_o.data   = data_i;
    cls_o.last   = last_i;
    cls_o.pay    = (kind_d == KindPay) && (pos_q >= cur_d);
    cls_o.sticky = sticky_d;
    cls_o.offset = cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindEth; pos_q <= '0; idx_q <= '0; len_q <= 8'd14;
      proto_q <= '0; tun_q <= 1'b0; chain_q <= '0; cur_q <= '0; sticky_q <= '0;
    end else if (fire) begin
      if (last_i) begin
        kind_q <= KindEth; pos_q <= '0; idx_q <= '0; len_q <= 8'd14;
        proto_q <= '0; tun_q <= 1'b0; chain_q <= '0; cur_q <= '0; sticky_q <= '0;
      end else begin
        kind_q <= kind_d; pos_q <= pos_d; idx_q <= idx_d; len_q <= len_d;
        proto_q <= proto_d; tun_q <= tun_d; chain_q <= chain_d; cur_q <= cur_d;
        sticky_q <= sticky_d;
      end
    end
  end

`ifndef ASSERT_OFF
  a_chain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_q <= MaxChain) else $error("chain count beyond limit");
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == KindStop) |-> (sticky_q != 3'd0)) else $error("stop without verdict");
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= MaxPos) else $error("position beyond limit");
`endif
endmodule

// ===== src/ppl_back.sv =====
module ppl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cls_valid_i,
  input  ppl_pkg::ppl_cls_t cls_i,
  output logic              cls_ready_o,
  output logic              res_valid_o,
  output ppl_pkg::ppl_res_t res_o,
  input  logic              res_ready_i
);
  import ppl_pkg::*;

  // Two-entry queue: full rate with a registered ready.
  ppl_cls_t    mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  ppl_cls_t    h;

  assign cls_ready_o = (cnt_q != 2'd2);
  assign push        = cls_valid_i && cls_ready_o;
  assign res_valid_o = (cnt_q != 2'd0);
  assign pop         = res_valid_o && res_ready_i;
  assign h           = mem_q[rp_q];

  always_comb begin
    res_o.data_out       = h.data;
    res_o.is_payload     = h.pay;
    res_o.last_out       = h.last;
    res_o.verdict        = VerdictPayload;
    res_o.payload_offset = '0;
    if (h.last) begin
      if (h.sticky != VerdictPayload) begin
        res_o.verdict = h.sticky;
      end else if (h.pay) begin
        res_o.payload_offset = h.offset;
      end else begin
        res_o.verdict = VerdictTruncated;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cls_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wp_q != rp_q)) else $error("pointer mismatch");
  a_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !h.last) |-> (res_o.verdict == VerdictPayload))
    else $error("verdict off the last item");
`endif
endmodule

// ===== src/packet_payload_locator_core.sv =====
// Packet payload locator: takes an Ethernet frame one byte per item, passes
// every byte through and marks the bytes at or after the payload offset,
// walking Ethernet/VLAN, IPv4/IPv6, IP-in-IP, IPv6 fragment, TCP and the
// fixed 8-byte headers. On the last item it gives the verdict and offset.
// Throughput is one item per cycle while the output accepts results: the front
// classifier updates its small counters as each byte is taken, and a two-entry
// queue before the result port lets the output stall without a bubble.
module packet_payload_locator_core #(
  parameter int unsigned MaxChainHeaders = ppl_pkg::MaxChainHeadersDefault,
  parameter int unsigned MaxFrameBytes   = ppl_pkg::MaxFrameBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppl_in_if.sink     in_i,
  ppl_out_if.source  out_o
);
  import ppl_pkg::*;

  logic     cls_valid, cls_ready;
  ppl_cls_t cls;
  ppl_res_t res;

  // Front: classify each byte against the header chain.
  ppl_front #(
    .MaxChainHeaders(MaxChainHeaders),
    .MaxFrameBytes  (MaxFrameBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .data_i     (in_i.data_byte),
    .last_i     (in_i.last),
    .ready_o    (in_i.ready),
    .cls_valid_o(cls_valid),
    .cls_o      (cls),
    .cls_ready_i(cls_ready)
  );

  // Back: hold items and form the verdict on the last one.
  ppl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cls_valid_i(cls_valid),
    .cls_i      (cls),
    .cls_ready_o(cls_ready),
    .res_valid_o(out_o.valid),
    .res_o      (res),
    .res_ready_i(out_o.ready)
  );

  assign out_o.data_out       = res.data_out;
  assign out_o.is_payload     = res.is_payload;
  assign out_o.last_out       = res.last_out;
  assign out_o.verdict        = res.verdict;
  assign out_o.payload_offset = res.payload_offset;

endmodule

// ===== bench/ppl_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side copies are not needed; the RTL interfaces are used directly.
// This file holds the stimulus item type shared by the bench.
package ppl_tb_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } frame_byte_t;
endpackage

// ===== bench/tb_packet_payload_locator_core.sv =====
`timescale 1ns / 1ps
module tb_packet_payload_locator_core;
  import ppl_pkg::*;
  import ppl_tb_pkg::*;

  localparam int unsigned ChainMax = MaxChainHeadersDefault;
  localparam int unsigned FrameMax = MaxFrameBytesDefault;
  localparam int unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;

  ppl_in_if  in_if ();
  ppl_out_if out_if ();

  packet_payload_locator_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  // Clock and reset: reset held low at the start, released once.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Locator state kept by the bench, mirroring the block's behaviour.
  int unsigned     pos_q;
  hdr_kind_e       kind_q;
  int unsigned     idx_q;
  int unsigned     hlen_q;
  int unsigned     proto_q;
  bit              tunnel_q;
  int unsigned     chain_q;
  int unsigned     offs_q;
  logic [2:0]      sticky_q;

  frame_byte_t     pending_bytes[$];
  ppl_res_t        expected_results[$];
  int unsigned     errors;
  int unsigned     cycles;
  int unsigned     frames_sent;
  int unsigned     results_seen;
  int unsigned     src_idle_pct;
  int unsigned     snk_idle_pct;
  bit              stim_done;

  function automatic void locator_clear();
    pos_q    = 0;
    kind_q   = KindEth;
    idx_q    = 0;
    hlen_q   = 14;
    proto_q  = 0;
    tunnel_q = 1'b0;
    chain_q  = 0;
    offs_q   = 0;
    sticky_q = VerdictPayload;
  endfunction

  function automatic void stop_walk(verdict_e v);
    sticky_q = v;
    kind_q   = KindStop;
  endfunction

  function automatic void open_header(hdr_kind_e k, int unsigned len);
    if (chain_q >= ChainMax) begin
      stop_walk(VerdictChainLong);
      return;
    end
    chain_q++;
    kind_q  = k;
    hlen_q  = len;
    idx_q   = 0;
    proto_q = 0;
  endfunction

  function automatic void open_protocol(int unsigned p);
    case (p)
      ProtoTcp: open_header(KindTcp, 20);
      ProtoIcmp, ProtoUdp, ProtoEsp, ProtoIcmp6: open_header(KindTerm, FixedHdrLen);
      ProtoIp6: open_header(KindTerm, 40);
      ProtoFrag: open_header(KindFrag, FixedHdrLen);
      ProtoIpip: begin
        if (tunnel_q) begin
          stop_walk(VerdictNestedIp);
        end else begin
          tunnel_q = 1'b1;
          open_header(KindIp4, 20);
        end
      end
      default: stop_walk(VerdictUnsupp);
    endcase
  endfunction

  function automatic void close_header();
    int unsigned sum;
    sum    = offs_q + hlen_q;
    offs_q = (sum > 16'hFFFF) ? 16'hFFFF : sum;
    if (kind_q == KindEth) begin
      if (proto_q == EtherIp4) open_header(KindIp4, 20);
      else if (proto_q == EtherIp6) open_header(KindIp6, 40);
      else stop_walk(VerdictNonIp);
    end else if (kind_q inside {KindIp4, KindIp6, KindFrag}) begin
      open_protocol(proto_q);
    end else begin
      kind_q = KindPay;
    end
  endfunction

  // Advance the walk by one byte and return the result item it gives.
  function automatic ppl_res_t locate_byte(frame_byte_t fb);
    ppl_res_t    r;
    int unsigned b;
    int unsigned here;
    b    = fb.data_byte;
    here = pos_q;
    if (kind_q != KindPay && kind_q != KindStop) begin
      case (kind_q)
        KindEth: begin
          if (idx_q inside {12, 13, 16, 17}) proto_q = ((proto_q << 8) | b) & 16'hFFFF;
          if (idx_q == 13 && hlen_q == 14 && proto_q == EtherVlan) hlen_q = 18;
        end
        KindIp4:  if (idx_q == 9) proto_q = b;
        KindIp6:  if (idx_q == 6) proto_q = b;
        KindFrag: if (idx_q == 0) proto_q = b;
        KindTcp:  if (idx_q == 12) hlen_q = ((b >> 4) & 4'hF) * WordBytes;
        default: ;
      endcase
      if (idx_q + 1 >= hlen_q) close_header();
      else idx_q = (idx_q + 1) & 8'hFF;
    end
    r = '0;
    r.data_out   = fb.data_byte;
    r.is_payload = (kind_q == KindPay && here >= offs_q);
    r.last_out   = fb.last;
    if (fb.last) begin
      if (sticky_q != VerdictPayload) r.verdict = sticky_q;
      else if (r.is_payload) r.payload_offset = offs_q[15:0];
      else r.verdict = VerdictTruncated;
    end
    if (fb.last) locator_clear();
    else if (pos_q < FrameMax) pos_q++;
    return r;
  endfunction

  // Frame building.
  task automatic push_byte(logic [7:0] b, logic l);
    frame_byte_t fb;
    fb.data_byte = b;
    fb.last      = l;
    pending_bytes.push_back(fb);
  endtask

  task automatic push_frame(ref logic [7:0] bytes[$]);
    for (int i = 0; i < bytes.size(); i++) push_byte(bytes[i], i == bytes.size() - 1);
    frames_sent++;
  endtask

  task automatic add_rand(ref logic [7:0] f[$], input int n);
    for (int i = 0; i < n; i++) f.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_eth(ref logic [7:0] f[$], input logic [15:0] et, input bit vlan);
    add_rand(f, 12);
    if (vlan) begin
      f.push_back(8'h81); f.push_back(8'h00); add_rand(f, 2);
    end
    f.push_back(et[15:8]); f.push_back(et[7:0]);
  endtask

  task automatic add_ip4(ref logic [7:0] f[$], input logic [7:0] p);
    add_rand(f, 9); f.push_back(p); add_rand(f, 10);
  endtask

  task automatic add_ip6(ref logic [7:0] f[$], input logic [7:0] p);
    add_rand(f, 6); f.push_back(p); add_rand(f, 33);
  endtask

  task automatic add_frag(ref logic [7:0] f[$], input logic [7:0] p);
    f.push_back(p); add_rand(f, 7);
  endtask

  task automatic add_tcp(ref logic [7:0] f[$], input logic [3:0] doff);
    add_rand(f, 12);
    f.push_back({doff, 4'($urandom_range(0, 15))});
    add_rand(f, 7);
  endtask

  function automatic logic [7:0] pick_proto();
    logic [7:0] table_p[9];
    table_p = '{ProtoTcp, ProtoUdp, ProtoIcmp, ProtoEsp, ProtoIcmp6, ProtoIp6,
                ProtoFrag, ProtoIpip, 8'd47};
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return table_p[$urandom_range(0, 8)];
  endfunction

  // Frame with random chain, at times with an unknown protocol or its last byte dropped; payload length may be zero.
  task automatic build_frame(input int depth_hint);
    logic [7:0] f[$];
    logic [7:0] p;
    bit         is6;
    int         n;
    is6 = ($urandom_range(0, 1) == 1);
    add_eth(f, is6 ? EtherIp6 : EtherIp4, $urandom_range(0, 3) == 0);
    p = pick_proto();
    if (is6) add_ip6(f, p); else add_ip4(f, p);
    n = 0;
    while ((p == ProtoIpip || p == ProtoFrag) && n < depth_hint) begin
      logic [7:0] q;
      q = pick_proto();
      if (p == ProtoIpip) add_ip4(f, q); else add_frag(f, q);
      p = q;
      n++;
    end
    if (p == ProtoTcp) add_tcp(f, 4'($urandom_range(0, 15)));
    else add_rand(f, 8);
    add_rand(f, $urandom_range(0, 6));
    if ($urandom_range(0, 9) == 0) void'(f.pop_back());
    if (f.size() == 0) f.push_back(8'h00);
    push_frame(f);
  endtask

  initial begin
    logic [7:0] f[$];
    locator_clear();
    errors = 0; frames_sent = 0; results_seen = 0;
    src_idle_pct = 12; snk_idle_pct = 62;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: single-byte frame, all-ones and all-zero bytes.
    f = {8'hFF}; push_frame(f);
    f = {}; for (int i = 0; i < 6; i++) f.push_back(8'h00); push_frame(f);
    // Non-IP ethertype, double VLAN.
    f = {}; add_eth(f, 16'h0806, 0); add_rand(f, 2); push_frame(f);
    f = {}; add_eth(f, EtherVlan, 1); add_rand(f, 2); push_frame(f);
    // UDP over IPv4 with VLAN.
    f = {}; add_eth(f, EtherIp4, 1); add_ip4(f, ProtoUdp); add_rand(f, 10); push_frame(f);
    // TCP with options and with a short data offset.
    f = {}; add_eth(f, EtherIp4, 0); add_ip4(f, ProtoTcp); add_tcp(f, 4'h6); add_rand(f, 6);
    push_frame(f);
    f = {}; add_eth(f, EtherIp4, 0); add_ip4(f, ProtoTcp); add_tcp(f, 4'h0); push_frame(f);
    // Nested tunnel.
    f = {}; add_eth(f, EtherIp4, 0); add_ip4(f, ProtoIpip); add_ip4(f, ProtoIpip);
    add_rand(f, 2); push_frame(f);
    // Long fragment chain: too many headers.
    f = {}; add_eth(f, EtherIp4, 0); add_ip4(f, ProtoFrag);
    for (int i = 0; i < ChainMax; i++) add_frag(f, ProtoFrag);
    add_rand(f, 1); push_frame(f);
    // Frame ending mid-header.
    f = {}; add_eth(f, EtherIp4, 0); add_rand(f, 5); push_frame(f);

    // Phases: directed frames first, then random frames with idling swapped, then random frames with no idling.
    for (int ph = 0; ph < 3; ph++) begin
      if (ph > 0) begin
        build_frame($urandom_range(0, 9));
        // Noise: a short random frame.
        f = {}; add_rand(f, $urandom_range(1, 20)); push_frame(f);
      end
      while (pending_bytes.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
      if (ph == 0) begin src_idle_pct = 62; snk_idle_pct = 12; end
      else begin src_idle_pct = 0; snk_idle_pct = 0; end
    end
    stim_done = 1'b1;
  end

  // Driver: hold an item until accepted, then advance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.data_byte <= '0;
      in_if.last      <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        frame_byte_t done_b;
        done_b = pending_bytes.pop_front();
        expected_results.push_back(locate_byte(done_b));
      end
      if ((!in_if.valid || in_if.ready)) begin
        if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_if.valid     <= 1'b1;
          in_if.data_byte <= pending_bytes[0].data_byte;
          in_if.last      <= pending_bytes[0].last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        ppl_res_t got, want;
        got = '{out_if.data_out, out_if.is_payload, out_if.last_out,
                out_if.verdict, out_if.payload_offset};
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Watchdog and end of run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** packet_payload_locator_core: FAILED **");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0) errors++;
    $display("Ran %0d frames, %0d byte results checked.", frames_sent, results_seen);
    if (errors == 0) begin
      $display("** packet_payload_locator_core: PASSED **");
    end else begin
      $display("** packet_payload_locator_core: FAILED **");
    end
    $finish;
  end

endmodule
